>>> sv/hvt_pkg.sv
`default_nettype none
package hvt_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = 4;
  localparam int COORD_W       = 32;
  localparam int PROD_W        = 2 * COORD_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int DIV_STEPS     = 32;
  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;
endpackage
`default_nettype wire

>>> sv/homogeneous_vertex_transform_unit.sv
`default_nettype none
// Transforms (x, y, z, 1) by a 4x4 Q-format matrix, then divides x', y', z' by w'.
// One point enters every clock unless the output stalls; the stages are one multiply
// stage, two adder stages, two divider setup stages, 32 stages of the pipelined
// restoring divider, output register. The three quotients are computed by three
// parallel one-bit-per-stage dividers, which sets the depth. A stalled output
// holds the whole pipeline. Matrix registers reset to identity and may be
// written only while no point is in flight; cfg_ready is always high.
module homogeneous_vertex_transform_unit import hvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [31:0]   in_coord_x,
  input  wire logic signed [31:0]   in_coord_y,
  input  wire logic signed [31:0]   in_coord_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic                      out_w_was_zero,
  output logic                      out_overflow,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);
  localparam int TW  = SUM_W - FRAC_BITS;
  localparam int DW  = TW + FRAC_BITS;
  localparam int NST = DIV_STEPS + 1;
  localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // matrix registers
  logic [63:0] mat_r [NUM_REGS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= {32'd0, ONE};
      mat_r[1] <= 64'd0;
      mat_r[2] <= {ONE, 32'd0};
      mat_r[3] <= 64'd0;
      mat_r[4] <= 64'd0;
      mat_r[5] <= {32'd0, ONE};
      mat_r[6] <= 64'd0;
      mat_r[7] <= {ONE, 32'd0};
    end else if (cfg_valid && (32'(cfg_index) < NUM_REGS)) begin
      mat_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  logic signed [31:0] cf [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      cf[r][0] = mat_r[2*r][31:0];
      cf[r][1] = mat_r[2*r][63:32];
      cf[r][2] = mat_r[2*r+1][31:0];
      cf[r][3] = mat_r[2*r+1][63:32];
    end
  end

  // stage 1: products
  logic signed [PROD_W-1:0] p_r [4][4];
  logic signed [PROD_W-1:0] p_nxt [4][4];
  logic s1_vld_r;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      p_nxt[c][0] = in_coord_x * cf[0][c];
      p_nxt[c][1] = in_coord_y * cf[1][c];
      p_nxt[c][2] = in_coord_z * cf[2][c];
      p_nxt[c][3] = {{(32-FRAC_BITS){cf[3][c][31]}}, cf[3][c], {FRAC_BITS{1'b0}}};
    end
  end

  // stage 2: pair sums, stage 3: column sums floor-shifted
  logic signed [PROD_W:0] a_r [4];
  logic signed [PROD_W:0] b_r [4];
  logic signed [SUM_W-1:0] s_nxt [4];
  logic signed [TW-1:0] t_r [4];
  logic s2_vld_r, s3_vld_r;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s_nxt[c] = a_r[c] + b_r[c];
    end
  end

  // stage 4: magnitudes
  logic [TW-1:0] un_r [3];
  logic [TW-1:0] ud4_r;
  logic [2:0]    neg4_r;
  logic          zero4_r, s4_vld_r;

  // divider pipeline, entry 0 loaded by stage 5
  logic [TW-1:0] rem_r [NST][3];
  logic [31:0]   lo_r  [NST][3];
  logic [31:0]   q_r   [NST][3];
  logic [2:0]    neg_r [NST];
  logic [2:0]    sat_r [NST];
  logic [TW-1:0] ud_r  [NST];
  logic          zero_r [NST];
  logic          dvld_r [NST];

  logic [DW-1:0] dd [3];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dd[l] = {un_r[l], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s4_vld_r  <= 1'b0;
      dvld_r[0] <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_valid;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
      s4_vld_r  <= s3_vld_r;
      dvld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= p_nxt;
      for (int c = 0; c < 4; c++) begin
        a_r[c] <= p_r[c][0] + p_r[c][1];
        b_r[c] <= p_r[c][2] + p_r[c][3];
        t_r[c] <= s_nxt[c][SUM_W-1:FRAC_BITS];
      end
      for (int l = 0; l < 3; l++) begin
        neg4_r[l] <= t_r[l][TW-1] ^ t_r[3][TW-1];
        un_r[l]   <= t_r[l][TW-1] ? TW'(-t_r[l]) : TW'(t_r[l]);
      end
      ud4_r   <= t_r[3][TW-1] ? TW'(-t_r[3]) : TW'(t_r[3]);
      zero4_r <= (t_r[3] == '0);
      // high part at or above divisor means quotient needs more than 32 bits
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l]  <= TW'(dd[l][DW-1:32]);
        lo_r[0][l]   <= dd[l][31:0];
        q_r[0][l]    <= '0;
        sat_r[0][l]  <= (TW'(dd[l][DW-1:32]) >= ud4_r);
      end
      neg_r[0]  <= neg4_r;
      ud_r[0]   <= ud4_r;
      zero_r[0] <= zero4_r;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [TW:0] trial [3];
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        trial[l] = {rem_r[k][l], lo_r[k][l][31]} - {1'b0, ud_r[k]};
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[k+1] <= 1'b0;
      end else if (adv) begin
        dvld_r[k+1] <= dvld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int l = 0; l < 3; l++) begin
          if (!trial[l][TW]) begin
            rem_r[k+1][l] <= trial[l][TW-1:0];
          end else begin
            rem_r[k+1][l] <= {rem_r[k][l][TW-2:0], lo_r[k][l][31]};
          end
          q_r[k+1][l]  <= {q_r[k][l][30:0], !trial[l][TW]};
          lo_r[k+1][l] <= {lo_r[k][l][30:0], 1'b0};
        end
        neg_r[k+1]  <= neg_r[k];
        sat_r[k+1]  <= sat_r[k];
        ud_r[k+1]   <= ud_r[k];
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  // output stage: sign, saturation, zero w
  logic [31:0] res_nxt [3];
  logic [2:0]  ovf_nxt;
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ovf_nxt[l] = sat_r[DIV_STEPS][l] ||
                   (neg_r[DIV_STEPS][l] ? (q_r[DIV_STEPS][l] > SAT_NEG)
                                        : (q_r[DIV_STEPS][l] > SAT_POS));
      if (ovf_nxt[l]) begin
        res_nxt[l] = neg_r[DIV_STEPS][l] ? SAT_NEG : SAT_POS;
      end else begin
        res_nxt[l] = neg_r[DIV_STEPS][l] ? -q_r[DIV_STEPS][l] : q_r[DIV_STEPS][l];
      end
    end
  end

  logic out_vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= dvld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero_r[DIV_STEPS]) begin
        out_x          <= '0;
        out_y          <= '0;
        out_z          <= '0;
        out_w_was_zero <= 1'b1;
        out_overflow   <= 1'b0;
      end else begin
        out_x          <= res_nxt[0];
        out_y          <= res_nxt[1];
        out_z          <= res_nxt[2];
        out_w_was_zero <= 1'b0;
        out_overflow   <= |ovf_nxt;
      end
    end
  end

  assign out_valid = out_vld_r;
endmodule
`default_nettype wire

>>> sv/hvt_checker.sv
`default_nettype none
module hvt_props (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] out_x,
  input wire logic signed [31:0] out_y,
  input wire logic signed [31:0] out_z,
  input wire logic               out_w_was_zero,
  input wire logic               out_overflow
);
  // held x and y results stay put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_zero_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_was_zero |->
      out_x == 0 && out_y == 0 && out_z == 0 && !out_overflow)
    else $error("zero w with nonzero result");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      out_x == 32'h7fffffff || out_x == 32'h80000000 ||
      out_y == 32'h7fffffff || out_y == 32'h80000000 ||
      out_z == 32'h7fffffff || out_z == 32'h80000000)
    else $error("overflow without saturated value");
endmodule

bind homogeneous_vertex_transform_unit hvt_props u_hvt_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_x          (out_x),
  .out_y          (out_y),
  .out_z          (out_z),
  .out_w_was_zero (out_w_was_zero),
  .out_overflow   (out_overflow)
);
`default_nettype wire

>>> tb/sv/hvt_checker.sv
module hvt_checker import hvt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_coord_x,
  input  logic signed [31:0] in_coord_y,
  input  logic signed [31:0] in_coord_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_x,
  input  logic signed [31:0] out_y,
  input  logic signed [31:0] out_z,
  input  logic               out_w_was_zero,
  input  logic               out_overflow,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 points_seen,
  output int                 sat_seen,
  output int                 zero_w_seen
);
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        ovf;
  } vertex_t;

  logic [63:0] matrix_regs [NUM_REGS];
  vertex_t     vertex_q [$];

  function automatic logic signed [31:0] coef(int r, int c);
    logic [63:0] w;
    w = matrix_regs[2 * r + c / 2];
    return (c % 2) ? w[63:32] : w[31:0];
  endfunction

  // exact column dot product, floor shifted
  function automatic logic signed [79:0] column_dot(logic signed [31:0] v[4], int c);
    logic signed [79:0] acc;
    acc = 0;
    for (int r = 0; r < 4; r++)
      acc += 80'(v[r]) * 80'(coef(r, c));
    return acc >>> FRAC_BITS_DEF;
  endfunction

  function automatic logic [31:0] quotient_sat(logic signed [79:0] n, logic signed [79:0] d,
                                               output logic ovf);
    logic        neg;
    logic [79:0] un, ud, q;
    logic [127:0] mag;
    logic [127:0] lim;
    neg = (n < 0) != (d < 0);
    un  = n < 0 ? -n : n;
    ud  = d < 0 ? -d : d;
    // truncation toward zero of (n << frac) / d
    mag = ({48'd0, un} << FRAC_BITS_DEF) / {48'd0, ud};
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    ovf = mag > lim;
    if (ovf) mag = lim;
    q = neg ? -mag[79:0] : mag[79:0];
    return q[31:0];
  endfunction

  function automatic vertex_t transform_point(logic signed [31:0] x, logic signed [31:0] y,
                                              logic signed [31:0] z);
    logic signed [31:0] v[4];
    logic signed [79:0] t[4];
    logic o0, o1, o2;
    vertex_t res;
    v[0] = x; v[1] = y; v[2] = z; v[3] = 32'sd1 <<< FRAC_BITS_DEF;
    for (int c = 0; c < 4; c++) t[c] = column_dot(v, c);
    res = '0;
    if (t[3] == 0) begin
      res.wz = 1'b1;
    end else begin
      res.x = quotient_sat(t[0], t[3], o0);
      res.y = quotient_sat(t[1], t[3], o1);
      res.z = quotient_sat(t[2], t[3], o2);
      res.ovf = o0 | o1 | o2;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    vertex_t e;
    if (!rst_n) begin
      matrix_regs[0] = 64'h1 << FRAC_BITS_DEF;
      matrix_regs[1] = 0;
      matrix_regs[2] = 64'h1 << (32 + FRAC_BITS_DEF);
      matrix_regs[3] = 0;
      matrix_regs[4] = 0;
      matrix_regs[5] = 64'h1 << FRAC_BITS_DEF;
      matrix_regs[6] = 0;
      matrix_regs[7] = 64'h1 << (32 + FRAC_BITS_DEF);
      vertex_q.delete();
      fail_count  <= 0;
      points_seen <= 0;
      sat_seen    <= 0;
      zero_w_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
        matrix_regs[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        vertex_q.push_back(transform_point(in_coord_x, in_coord_y, in_coord_z));
      if (out_valid && out_ready) begin
        points_seen <= points_seen + 1;
        if (out_overflow) sat_seen <= sat_seen + 1;
        if (out_w_was_zero) zero_w_seen <= zero_w_seen + 1;
        if (vertex_q.size() == 0) begin
          if (fail_count < 10) $display("checker: result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = vertex_q.pop_front();
          if (e.x !== out_x || e.y !== out_y || e.z !== out_z ||
              e.wz !== out_w_was_zero || e.ovf !== out_overflow) begin
            if (fail_count < 10)
              $display("checker: mismatch exp %h %h %h wz%b ov%b got %h %h %h wz%b ov%b",
                       e.x, e.y, e.z, e.wz, e.ovf,
                       out_x, out_y, out_z, out_w_was_zero, out_overflow);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= vertex_q.size();
  end
endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import hvt_pkg::*;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_w_was_zero, out_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int fail_count, pending, points_seen, sat_seen, zero_w_seen;
  int cycle_count = 0;
  int sink_idle_pct = 0;
  bit sink_hold = 1'b0;
  bit stimulus_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  homogeneous_vertex_transform_unit dut (.*);

  hvt_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk)
    out_ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx[REG_IDX_W-1:0];
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      2: return {{16{1'($urandom_range(1))}}, 16'($urandom())};
      default: return $urandom() >>> $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(32'h0002_0000) - 32'h0001_0000;
      default: return $urandom_range(1) ? 32'h0001_0000 : 32'h0;
    endcase
  endfunction

  task automatic load_matrix(int mode);
    for (int i = 0; i < NUM_REGS; i++)
      write_reg(i, {rand_coef(mode), rand_coef(mode)});
  endtask

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity: extremes pass through
    sink_idle_pct = 14;
    send_point(0, 0, 0, 0);
    send_point(MAXC, MINC, 32'hffff_ffff, 0);
    send_point(MINC, MAXC, 32'h0001_0000, 0);
    send_point(32'hffff_ffff, 32'h0000_0001, MAXC, 0);
    drain_pipe();

    // w from z: zero w, tiny negative w, saturation
    write_reg(0, 64'h0000_0000_0001_0000);
    write_reg(1, 64'h0);
    write_reg(2, 64'h0001_0000_0000_0000);
    write_reg(3, 64'h0);
    write_reg(4, 64'h0);
    write_reg(5, 64'h0001_0000_0001_0000);
    write_reg(6, 64'h0);
    write_reg(7, 64'h0);
    write_reg(9, 64'hdead_beef_dead_beef); // out of range, ignored
    send_point(32'h0001_0000, 32'h0002_0000, 0, 0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0001, 0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'hffff_ffff, 0);
    send_point(MAXC, MINC, 32'h0000_0100, 0);
    send_point(MINC, MAXC, 32'hffff_ff00, 0);
    send_point(MINC, MINC, MINC, 0);
    send_point(MAXC, MAXC, MAXC, 0);
    send_point(32'h0003_0000, 32'hfffd_0000, 32'h0002_0000, 0);
    drain_pipe();

    // extreme coefficients everywhere
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, {MINC, MAXC});
    send_point(MAXC, MAXC, MAXC, 0);
    send_point(MINC, MINC, MINC, 0);
    send_point(MAXC, MINC, 0, 0);
    drain_pipe();
    for (int i = 0; i < NUM_REGS; i++) write_reg(i, 64'hffff_ffff_ffff_ffff);
    send_point(MAXC, 1, 32'hffff_ffff, 0);
    send_point(0, 0, 0, 0);
    drain_pipe();

    for (int phase = 0; phase < 8; phase++) begin
      load_matrix(phase % 3);
      if (phase == 2) begin
        sink_hold = 1'b1;
        fork
          begin
            repeat (300) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      sink_idle_pct = (phase == 4) ? 0 : 14;
      for (int n = 0; n < 66; n++)
        send_point(rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
                   rand_coord($urandom_range(3)), (phase == 4) ? 0 : 14);
      drain_pipe();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    $display("tb_top: %0d points checked, %0d saturated, %0d with zero w",
             points_seen, sat_seen, zero_w_seen);
    if (fail_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end
endmodule

>>> sim.f
sv/hvt_pkg.sv
sv/homogeneous_vertex_transform_unit.sv
sv/hvt_checker.sv
tb/sv/hvt_checker.sv
tb/sv/tb_top.sv
